// ===== src/sepq_pkg.sv =====
// Shared types, constants and codes for the sorted event priority queue.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sepq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // request kinds
    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_POP      = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_POPPED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    typedef struct packed {
        logic [TIME_BITS-1:0] tstamp;
        logic [2:0]           kind;
        logic [3:0]           machine;
        logic [31:0]          arrival;
    } slot_t;

    // controller to datapath commands
    typedef struct packed {
        logic             insert;
        logic             shift_out;
        logic             load_result;
        logic [CNT_W-1:0] live_count;
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/sepq_datapath.sv =====
// Slot shift line, parallel insert compare and result payload register.
// Depends on sepq_pkg; driven by commands from sepq_controller.
`timescale 1ns / 1ps
`default_nettype none

module sepq_datapath (
    input  wire logic           aclk,
    input  sepq_pkg::cmd_t      cmd,
    input  sepq_pkg::slot_t     new_slot,
    output sepq_pkg::slot_t     result
);
    import sepq_pkg::*;

    slot_t                  slot_reg [QUEUE_DEPTH];
    slot_t                  slot_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] less;
    slot_t                  result_reg;
    slot_t                  result_next;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
            localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

            // live and strictly earlier than the new notice
            assign less[i] = (IDX < cmd.live_count) &&
                             (slot_reg[i].tstamp < new_slot.tstamp);

            always_comb begin
                slot_next[i] = slot_reg[i];
                if (cmd.insert) begin
                    if (!less[i]) begin
                        if (i == 0) begin
                            slot_next[i] = new_slot;
                        end else if (less[(i == 0) ? 0 : i - 1]) begin
                            slot_next[i] = new_slot;
                        end else begin
                            slot_next[i] = slot_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                end else if (cmd.shift_out) begin
                    // advance towards the head; the tail slot holds
                    if (i < QUEUE_DEPTH - 1) begin
                        slot_next[i] = slot_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    endgenerate

    always_comb begin
        result_next = result_reg;
        if (cmd.load_result) begin
            result_next = cmd.shift_out ? slot_reg[0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/sepq_controller.sv =====
// Occupancy count, result status and output handshake state machine.
// Depends on sepq_pkg; issues commands to sepq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sepq_controller (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   req_valid,
    input  wire logic                   req_op,
    output logic                        req_ready,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output logic [1:0]                  res_status,
    output logic [sepq_pkg::CNT_W-1:0]  count,
    output sepq_pkg::cmd_t              cmd
);
    import sepq_pkg::*;

    typedef enum logic {
        OUT_IDLE,
        OUT_FULL
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       status_reg, status_next;
    logic             accept;
    logic             is_full;
    logic             is_empty;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    assign req_ready = (state_reg == OUT_IDLE) || res_ready;
    assign accept    = req_valid && req_ready;
    assign is_full   = (count_reg == DEPTH_C);
    assign is_empty  = (count_reg == '0);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        cmd.insert      = 1'b0;
        cmd.shift_out   = 1'b0;
        cmd.load_result = accept;
        cmd.live_count  = count_reg;
        if (accept) begin
            state_next = OUT_FULL;
            case (req_op)
                OP_SCHEDULE: begin
                    if (is_full) begin
                        status_next = ST_DROPPED;
                    end else begin
                        status_next = ST_INSERTED;
                        count_next  = count_reg + CNT_W'(1);
                        cmd.insert  = 1'b1;
                    end
                end
                OP_POP: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        status_next   = ST_POPPED;
                        count_next    = count_reg - CNT_W'(1);
                        cmd.shift_out = 1'b1;
                    end
                end
                default: begin
                    status_next = ST_EMPTY;
                end
            endcase
        end else if (res_ready) begin
            state_next = OUT_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= OUT_IDLE;
            count_reg  <= '0;
            status_reg <= ST_INSERTED;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign res_valid  = (state_reg == OUT_FULL);
    assign res_status = status_reg;
    assign count      = count_reg;

endmodule

`default_nettype wire

// ===== src/sorted_event_priority_queue.sv =====
// Top level of the sorted event priority queue: stream ports and packing.
// Depends on sepq_pkg, sepq_controller and sepq_datapath.
//
// A future-event list of QUEUE_DEPTH notices held in a register shift line, sorted
// by time with the earliest at the head. A schedule request (s_tuser = 0) inserts
// its notice ahead of any stored notice of equal time; a pop request (s_tuser = 1)
// removes and returns the head. Every request gives exactly one result with a
// status in m_tuser: inserted, popped, pop on empty list, or insert dropped because
// the list is full; the notice fields are zero unless popped. One request is taken
// per clock, sustained: all slots compare against the new time in parallel and the
// whole line shifts in the same cycle, and the single result register on the
// master side lets a new request in whenever its result is taken that cycle. The
// result is registered and appears in the cycle after the request is accepted. No
// clearing pass after reset: only the count, state and status are reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_event_priority_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] event_time, [34:32] event_kind, [38:35] machine_number,
    // [70:39] arrival_stamp, [71] zero
    input  wire logic [71:0] s_tdata,
    // [0] op
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] out_time, [34:32] out_kind, [38:35] out_machine,
    // [70:39] out_arrival, [75:71] entry_count, [79:76] zero
    output logic [79:0]      m_tdata,
    // [1:0] status
    output logic [1:0]       m_tuser
);
    import sepq_pkg::*;

    cmd_t             cmd;
    slot_t            new_slot;
    slot_t            result;
    logic [CNT_W-1:0] count;

    assign new_slot.tstamp  = TIME_BITS'(s_tdata[31:0]);
    assign new_slot.kind    = s_tdata[34:32];
    assign new_slot.machine = s_tdata[38:35];
    assign new_slot.arrival = s_tdata[70:39];

    sepq_controller u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_op     (s_tuser[0]),
        .req_ready  (s_tready),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (m_tuser),
        .count      (count),
        .cmd        (cmd)
    );

    sepq_datapath u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .new_slot (new_slot),
        .result   (result)
    );

    assign m_tdata = {4'b0, 5'(count), result.arrival, result.machine, result.kind,
                      32'(result.tstamp)};

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= DEPTH_C)
        else $error("entry count beyond depth");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_tvalid)
        else $error("accepted request gave no result");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser[0] == OP_POP && count == '0) |=>
        (m_tuser == ST_EMPTY && count == '0))
        else $error("pop on empty list misreported");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser[0] == OP_SCHEDULE && count == DEPTH_C) |=>
        (m_tuser == ST_DROPPED && $stable(count)))
        else $error("insert on full list not dropped");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_POPPED) |-> (m_tdata[70:0] == '0))
        else $error("notice fields not zero on non-pop result");

endmodule

`default_nettype wire
